// ===== rtl/dtsm_pkg.sv =====
// Shared constants for the double-to-timespec (millisecond) converter.
// No dependencies.
package dtsm_pkg;

	// Default signed width of the whole-seconds result
	localparam int SEC_BITS_DEF = 64;

	// Status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NOT_FINITE = 2'd1;
	localparam logic [1:0] ST_RANGE      = 2'd2;

	// Scale factors
	localparam int MS_PER_SEC = 1000;
	localparam int NS_PER_MS  = 1000000;

	// binary64 layout
	localparam int        EXP_BIAS = 1023;
	localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;

endpackage

// ===== rtl/double_to_timespec_ms_core.sv =====
// Top level of the double-to-timespec converter: five-stage pipeline.
// Depends on dtsm_pkg.
//
// Converts a binary64 time in seconds into floor seconds plus nanoseconds at
// millisecond resolution (fraction times 1000, rounded as a double, then
// rounded half away from zero, carrying into seconds at 1000 ms). A request
// is taken every cycle while in_stall is low; results leave in request order.
// The pipeline is decode, shift/align, multiply by 1000 with seconds assembly,
// leading-one search and mantissa rounding, then millisecond rounding, carry
// and range check into the output register. A stall on the output only holds
// the stages that are full, so empty stages keep filling. NaN and infinity
// give status 1, seconds outside the signed SEC_BITS range give status 2;
// both return zero seconds and nanoseconds.
module double_to_timespec_ms_core #(
	parameter int SEC_BITS = dtsm_pkg::SEC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [63:0]         value_bits,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [SEC_BITS-1:0] whole_seconds,
	output logic [29:0]         nanoseconds,
	output logic [1:0]          status
);

	localparam logic signed [65:0] SEC_MAX = 66'sd1 <<< (SEC_BITS - 1);

	// Stage enables: a stage moves when it is empty or the next one moves
	logic en1, en2, en3, en4, en5;
	logic v1_s1, v2_s2, v3_s3, v4_s4;

	assign en5 = !out_valid || !out_stall;
	assign en4 = !v4_s4 || en5;
	assign en3 = !v3_s3 || en4;
	assign en2 = !v2_s2 || en3;
	assign en1 = !v1_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1     <= 1'b0;
			v2_s2     <= 1'b0;
			v3_s3     <= 1'b0;
			v4_s4     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (en1) v1_s1 <= in_valid;
			if (en2) v2_s2 <= v1_s1;
			if (en3) v3_s3 <= v2_s2;
			if (en4) v4_s4 <= v3_s3;
			if (en5) out_valid <= v4_s4;
		end
	end

	// ---------------- Stage 1: field decode ----------------
	logic               nonfin_c, zero_c;
	logic signed [11:0] exp_c;
	logic               nonfin_s1, neg_s1;
	logic signed [11:0] exp_s1;
	logic [52:0]        sig_s1;

	assign nonfin_c = value_bits[62:52] == dtsm_pkg::EXP_ALL_ONES;
	assign zero_c   = value_bits[62:0] == 63'd0;
	assign exp_c    = (value_bits[62:52] == 11'd0) ? -12'sd1022 :
		$signed({1'b0, value_bits[62:52]}) - 12'(dtsm_pkg::EXP_BIAS);

	always_ff @(posedge clk) begin
		if (en1) begin
			nonfin_s1 <= nonfin_c;
			neg_s1    <= value_bits[63] && !zero_c;
			exp_s1    <= exp_c;
			sig_s1    <= {value_bits[62:52] != 11'd0, value_bits[51:0]};
		end
	end

	// ---------------- Stage 2: integer / fraction split ----------------
	// Fraction is F * 2^-s; for negatives it is 1 - |fraction|, rounded to
	// double when |value| < 1.
	logic [63:0]  imag_c;
	logic         frnz_c, huge_c;
	logic [53:0]  f_c;
	logic [6:0]   s_c;
	logic [5:0]   sh_c;
	logic [52:0]  fr_c;
	logic [11:0]  nsh_c;
	logic [5:0]   nshc_c;
	logic [116:0] t_c;
	logic [52:0]  u_c;

	// Rounding of |value| in units of 2^-53 for small negatives
	always_comb begin
		nsh_c  = 12'(-exp_s1 - 12'sd1);
		nshc_c = (nsh_c > 12'd63) ? 6'd63 : nsh_c[5:0];
		t_c    = {sig_s1, 64'd0} >> nshc_c;
		u_c    = t_c[116:64] + 53'(t_c[63] && ((|t_c[62:0]) || t_c[64]));
	end

	always_comb begin
		imag_c = 64'd0;
		frnz_c = 1'b0;
		huge_c = 1'b0;
		f_c    = 54'd0;
		s_c    = 7'd1;
		sh_c   = 6'd0;
		fr_c   = 53'd0;
		if (exp_s1 >= 12'sd64) begin
			huge_c = 1'b1;
		end else if (exp_s1 >= 12'sd52) begin
			imag_c = {11'd0, sig_s1} << 6'(exp_s1 - 12'sd52);
		end else if (exp_s1 >= 12'sd0) begin
			sh_c   = 6'(12'sd52 - exp_s1);
			imag_c = {11'd0, sig_s1} >> sh_c;
			fr_c   = sig_s1 & ((53'd1 << sh_c) - 53'd1);
			frnz_c = |fr_c;
			s_c    = {1'b0, sh_c};
			f_c    = (neg_s1 && frnz_c) ? (54'd1 << sh_c) - {1'b0, fr_c} : {1'b0, fr_c};
		end else if (!neg_s1) begin
			// below 2^-11 the milliseconds round to zero
			if (exp_s1 > -12'sd12) begin
				f_c = {1'b0, sig_s1};
				s_c = 7'(12'sd52 - exp_s1);
			end
		end else begin
			frnz_c = 1'b1;
			s_c    = 7'd53;
			if (exp_s1 == -12'sd1)
				f_c = (54'd1 << 53) - {1'b0, sig_s1};
			else
				f_c = (54'd1 << 53) - {1'b0, u_c};
		end
	end

	logic        nonfin_s2, neg_s2, huge_s2, frnz_s2;
	logic [63:0] imag_s2;
	logic [53:0] f_s2;
	logic [6:0]  s_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			nonfin_s2 <= nonfin_s1;
			neg_s2    <= neg_s1;
			huge_s2   <= huge_c;
			frnz_s2   <= frnz_c;
			imag_s2   <= imag_c;
			f_s2      <= f_c;
			s_s2      <= s_c;
		end
	end

	// ---------------- Stage 3: fraction * 1000, floor seconds ----------------
	logic [63:0]        fw_c, q_c;
	logic [65:0]        mag_c;
	logic signed [65:0] sec_c;

	always_comb begin
		fw_c  = {10'd0, f_s2};
		q_c   = (fw_c << 10) - (fw_c << 4) - (fw_c << 3);
		mag_c = {2'b0, imag_s2} + 66'(frnz_s2);
		sec_c = neg_s2 ? -$signed(mag_c) : $signed({2'b0, imag_s2});
	end

	logic               nonfin_s3, huge_s3;
	logic [63:0]        q_s3;
	logic [6:0]         s_s3;
	logic signed [65:0] sec_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			nonfin_s3 <= nonfin_s2;
			huge_s3   <= huge_s2;
			q_s3      <= q_c;
			s_s3      <= s_s2;
			sec_s3    <= sec_c;
		end
	end

	// ---------------- Stage 4: round product to 53 significant bits ----------------
	logic [5:0]  lead_c;
	logic [3:0]  d_c;
	logic [63:0] keep_c, r_c;
	logic        g_c, st_c;

	always_comb begin
		lead_c = 6'd0;
		for (int i = 0; i < 64; i++) begin
			if (q_s3[i]) lead_c = 6'(i);
		end
		d_c    = (lead_c >= 6'd53) ? 4'(lead_c - 6'd52) : 4'd0;
		keep_c = q_s3 >> d_c;
		g_c    = (d_c != 4'd0) && q_s3[6'(d_c - 4'd1)];
		st_c   = (d_c > 4'd1) && |(q_s3 & ((64'd1 << (d_c - 4'd1)) - 64'd1));
		r_c    = (keep_c + 64'(g_c && (st_c || keep_c[0]))) << d_c;
	end

	logic               nonfin_s4, huge_s4;
	logic [63:0]        r_s4;
	logic [6:0]         s_s4;
	logic signed [65:0] sec_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			nonfin_s4 <= nonfin_s3;
			huge_s4   <= huge_s3;
			r_s4      <= r_c;
			s_s4      <= s_s3;
			sec_s4    <= sec_s3;
		end
	end

	// ---------------- Stage 5: ms rounding, carry, range check ----------------
	logic [64:0]        msw_c;
	logic [10:0]        ms_c;
	logic               carry_c, oor_c;
	logic [9:0]         msf_c;
	logic signed [65:0] secf_c;

	always_comb begin
		msw_c   = ({1'b0, r_s4} + (65'd1 << (s_s4 - 7'd1))) >> s_s4;
		ms_c    = msw_c[10:0];
		carry_c = ms_c >= 11'(dtsm_pkg::MS_PER_SEC);
		msf_c   = carry_c ? 10'd0 : ms_c[9:0];
		secf_c  = sec_s4 + 66'(carry_c);
		oor_c   = huge_s4 || (secf_c >= SEC_MAX) || (secf_c < -SEC_MAX);
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			if (nonfin_s4) begin
				whole_seconds <= '0;
				nanoseconds   <= 30'd0;
				status        <= dtsm_pkg::ST_NOT_FINITE;
			end else if (oor_c) begin
				whole_seconds <= '0;
				nanoseconds   <= 30'd0;
				status        <= dtsm_pkg::ST_RANGE;
			end else begin
				whole_seconds <= secf_c[SEC_BITS-1:0];
				nanoseconds   <= 30'(msf_c) * 30'(dtsm_pkg::NS_PER_MS);
				status        <= dtsm_pkg::ST_OK;
			end
		end
	end

endmodule

// ===== sim/double_to_timespec_ms_core_tb.sv =====
// Testbench for double_to_timespec_ms_core: directed table, then random binary64 requests.
// Every result is checked against a predictor that uses the simulator's real arithmetic.
// Depends on dtsm_pkg and the RTL top level.
module double_to_timespec_ms_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SB = dtsm_pkg::SEC_BITS_DEF;

	typedef struct packed {
		logic [SB-1:0] secs;
		logic [29:0]   ns;
		logic [1:0]    st;
	} ts_t;

	// One row of the directed table; chk says the expected value is typed in
	typedef struct {
		logic [63:0] bits;
		bit          chk;
		ts_t         want;
	} row_t;

	logic          clk, arst_n;
	logic          in_valid, out_stall;
	logic          in_stall, out_valid;
	logic [63:0]   value_bits;
	logic [SB-1:0] whole_seconds;
	logic [29:0]   nanoseconds;
	logic [1:0]    status;

	ts_t pending_ts[$];
	int  mismatches;

	double_to_timespec_ms_core #(.SEC_BITS(SB)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .value_bits(value_bits),
		.out_valid(out_valid), .out_stall(out_stall),
		.whole_seconds(whole_seconds), .nanoseconds(nanoseconds), .status(status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Floor of a finite double; anything at least 2^52 in magnitude is whole already
	function automatic real floor_real(real x);
		longint i;
		real d;
		if (x >= 4503599627370496.0 || x <= -4503599627370496.0)
			return x;
		i = longint'(x);
		d = real'(i);
		if (d > x)
			d = d - 1.0;
		return d;
	endfunction

	function automatic ts_t convert_time(logic [63:0] b);
		ts_t r;
		real v, s, f, p, lim;
		longint ms;
		r = '0;
		if (b[62:52] == dtsm_pkg::EXP_ALL_ONES) begin
			r.st = dtsm_pkg::ST_NOT_FINITE;
			return r;
		end
		v = $bitstoreal(b);
		s = floor_real(v);
		p = (v - s) * 1000.0;
		f = floor_real(p);
		ms = longint'(f);
		if (p - f >= 0.5)
			ms++;
		if (ms >= dtsm_pkg::MS_PER_SEC) begin
			s = s + 1.0;
			ms = 0;
		end
		lim = 2.0 ** (SB - 1);
		if (s >= lim || s < -lim) begin
			r.st = dtsm_pkg::ST_RANGE;
			return r;
		end
		r.secs = SB'(longint'(s));
		r.ns = 30'(ms * dtsm_pkg::NS_PER_MS);
		r.st = dtsm_pkg::ST_OK;
		return r;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 2) == 0)
			return 0;
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(0, 3);
	endfunction

	// Random binary64 patterns weighted toward exponents that exercise the fraction
	function automatic logic [63:0] rand_double();
		logic [63:0] b;
		int k;
		b = {$urandom, $urandom};
		k = $urandom_range(0, 9);
		if (k < 6)
			b[62:52] = 11'($urandom_range(dtsm_pkg::EXP_BIAS - 12, dtsm_pkg::EXP_BIAS + 40));
		else if (k == 6)
			b[62:52] = 11'($urandom_range(dtsm_pkg::EXP_BIAS + 50, dtsm_pkg::EXP_BIAS + 64));
		else if (k == 7)
			b[62:52] = $urandom_range(0, 1) ? dtsm_pkg::EXP_ALL_ONES
				: 11'($urandom_range(0, 3));
		else if (k == 8) begin
			// fraction near a millisecond boundary
			b = $realtobits($itor($urandom_range(0, 5000)) - 2500.0
				+ ($itor($urandom_range(0, 1000)) + 0.5) / 1000.0);
			b[3:0] = 4'($urandom);
		end
		return b;
	endfunction

	task automatic send_request(logic [63:0] b);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1'b1;
		value_bits <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_ts.push_back(convert_time(b));
		@(negedge clk);
	endtask

	// Directed stimulus
	row_t dir_rows[$];
	function automatic row_t mk(logic [63:0] b, bit c, ts_t w);
		row_t r;
		r.bits = b; r.chk = c; r.want = w;
		return r;
	endfunction

	initial begin
		ts_t zero_ok, nf, rng, w;
		zero_ok = '0;
		nf = '0; nf.st = dtsm_pkg::ST_NOT_FINITE;
		rng = '0; rng.st = dtsm_pkg::ST_RANGE;
		dir_rows.push_back(mk(64'h0000000000000000, 1, zero_ok));
		dir_rows.push_back(mk(64'h8000000000000000, 1, zero_ok));  // negative zero
		dir_rows.push_back(mk(64'h7FF0000000000000, 1, nf));       // +inf
		dir_rows.push_back(mk(64'hFFF0000000000000, 1, nf));       // -inf
		dir_rows.push_back(mk(64'h7FF8000000000001, 1, nf));       // NaN
		dir_rows.push_back(mk(64'hFFFFFFFFFFFFFFFF, 1, nf));
		dir_rows.push_back(mk(64'h43E0000000000000, 1, rng));      // 2^63
		dir_rows.push_back(mk(64'h7FEFFFFFFFFFFFFF, 1, rng));      // max finite
		dir_rows.push_back(mk(64'hFFEFFFFFFFFFFFFF, 1, rng));
		w = '0; w.secs = {1'b1, {(SB-1){1'b0}}};
		dir_rows.push_back(mk(64'hC3E0000000000000, 1, w));        // -2^63 exact
		w = '0; w.secs = SB'(1);
		dir_rows.push_back(mk(64'h3FF0000000000000, 1, w));        // 1.0
		w = '0; w.secs = '1;
		dir_rows.push_back(mk(64'hBFF0000000000000, 1, w));        // -1.0
		dir_rows.push_back(mk(64'h0000000000000001, 1, zero_ok));  // min subnormal
		w = '0; w.secs = '1;
		dir_rows.push_back(mk(64'h8000000000000001, 0, w));        // -subnormal carries
		dir_rows.push_back(mk(64'h3FE0000000000000, 0, w));        // 0.5
		dir_rows.push_back(mk(64'h3FEFFFFFFFFFFFFF, 0, w));        // just below 1: carry
		dir_rows.push_back(mk($realtobits(2.0005), 0, w));         // half ms
		dir_rows.push_back(mk($realtobits(-2.0005), 0, w));
		dir_rows.push_back(mk($realtobits(3.9996), 0, w));
		dir_rows.push_back(mk($realtobits(1.0e15 + 0.25), 0, w));
		dir_rows.push_back(mk(64'h4330000000000001, 0, w));        // above 2^52
		dir_rows.push_back(mk(64'h43DFFFFFFFFFFFFF, 0, w));        // just below 2^63
		dir_rows.push_back(mk(64'h000FFFFFFFFFFFFF, 0, w));
	end

	// Output side: random stall, compare with the oldest expectation
	always @(posedge clk) begin
		ts_t exp_ts;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_ts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result secs=%h ns=%0d st=%0d",
						whole_seconds, nanoseconds, status);
			end else begin
				exp_ts = pending_ts.pop_front();
				if (whole_seconds !== exp_ts.secs || nanoseconds !== exp_ts.ns
						|| status !== exp_ts.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp secs=%h ns=%0d st=%0d, got secs=%h ns=%0d st=%0d",
							exp_ts.secs, exp_ts.ns, exp_ts.st,
							whole_seconds, nanoseconds, status);
				end
			end
		end
	end

	initial begin
		int g;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			g = gap_len();
			if (g > 0) begin
				out_stall <= 1'b1;
				repeat (g - 1) @(negedge clk);
			end else
				out_stall <= 1'b0;
		end
	end

	// Directed rows carry typed-in expectations where given
	initial begin
		in_valid = 1'b0;
		value_bits = '0;
		arst_n = 1'b0;
		mismatches = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (dir_rows[i]) begin
			send_request(dir_rows[i].bits);
			if (dir_rows[i].chk && pending_ts[$] !== dir_rows[i].want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("predictor disagrees with table row %0d", i);
			end
		end
		for (int n = 0; n < 1650; n++)
			send_request(rand_double());
		in_valid <= 1'b0;
		while (pending_ts.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("[double_to_timespec_ms_core] OK");
		else
			$display("[double_to_timespec_ms_core] ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("[double_to_timespec_ms_core] ERROR");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/dtsm_pkg.sv
rtl/double_to_timespec_ms_core.sv
sim/double_to_timespec_ms_core_tb.sv
